// ----- rtl/core/mppt_ic_pkg.sv -----
// ----------------------------------------------------------------------------
// mppt_ic_pkg
// Shared types and constants of the incremental-conductance tracker: controller
// states, action codes, register indexes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package mppt_ic_pkg;

    // fixed field widths
    localparam int SAMPLE_COUNT_W = 13;
    localparam int DUTY_W         = 7;

    // configuration register reset values
    localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 13'd1000;
    localparam logic [DUTY_W-1:0]         DUTY_MAX_RST     = 7'd80;
    localparam logic [DUTY_W-1:0]         DUTY_MIN_RST     = 7'd20;

    // register indexes (word address)
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_DUTY_MAX     = 2'd1;
    localparam logic [1:0] REG_DUTY_MIN     = 2'd2;

    // tracking step outcome
    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_RAISED  = 3'd1,
        ACT_LOWERED = 3'd2,
        ACT_AT_MAX  = 3'd3,
        ACT_AT_MIN  = 3'd4
    } action_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DIFF,
        ST_MULT,
        ST_STEP
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_step;
        logic diff;
        logic mul;
        logic step;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic close;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/mppt_ic_ctrl.sv -----
// ----------------------------------------------------------------------------
// mppt_ic_ctrl
// Sequencer of the tracker: accepts samples, and when a window closes walks
// the datapath through divide, difference, multiply and step phases.
// ----------------------------------------------------------------------------
module mppt_ic_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  mppt_ic_pkg::dp_status_t status,
    output mppt_ic_pkg::dp_cmd_t    cmd
);
    import mppt_ic_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.close)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DIFF:
            begin
                cmd.diff = 1'b1;
            end
            ST_MULT:
            begin
                cmd.mul = 1'b1;
            end
            ST_STEP:
            begin
                cmd.step = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/mppt_ic_datapath.sv -----
// ----------------------------------------------------------------------------
// mppt_ic_datapath
// Window sums, a pair of bit-serial restoring dividers for the averages, the
// cross-multiplication of the conductance test and the duty update with its
// output register.
// ----------------------------------------------------------------------------
module mppt_ic_datapath #(
    parameter int ADC_BITS   = 12,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [ADC_BITS-1:0]                       voltage_sample,
    input  logic [ADC_BITS-1:0]                       current_sample,
    input  logic [mppt_ic_pkg::SAMPLE_COUNT_W-1:0]    sample_count,
    input  logic [mppt_ic_pkg::DUTY_W-1:0]            duty_max,
    input  logic [mppt_ic_pkg::DUTY_W-1:0]            duty_min,
    input  mppt_ic_pkg::dp_cmd_t                      cmd,
    output mppt_ic_pkg::dp_status_t                   status,
    input  logic                                      out_ready,
    output logic                                      out_valid,
    output logic [mppt_ic_pkg::DUTY_W-1:0]            duty_percent,
    output logic [ADC_BITS-1:0]                       avg_voltage,
    output logic [ADC_BITS-1:0]                       avg_current,
    output mppt_ic_pkg::action_t                      action
);
    import mppt_ic_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int DIF_W  = ADC_BITS + 1;
    localparam int PROD_W = 2 * DIF_W;
    localparam int S_W    = PROD_W + 1;

    logic [IDX_W-1:0]      sample_index_reg;
    logic [SUM_W-1:0]      voltage_sum_reg;
    logic [SUM_W-1:0]      current_sum_reg;
    logic [ADC_BITS-1:0]   prev_avg_voltage_reg;
    logic [ADC_BITS-1:0]   prev_avg_current_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic [DCNT_W-1:0]     div_count_reg;
    logic                  out_valid_reg;

    logic [SUM_W-1:0]      vq_reg;
    logic [SUM_W-1:0]      iq_reg;
    logic [CNT_W-1:0]      vrem_reg;
    logic [CNT_W-1:0]      irem_reg;
    logic [CNT_W-1:0]      divisor_reg;
    logic signed [DIF_W-1:0]  dv_reg;
    logic signed [DIF_W-1:0]  di_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic signed [PROD_W-1:0] p2_reg;
    logic [DUTY_W-1:0]     duty_out_reg;
    logic [ADC_BITS-1:0]   avg_v_out_reg;
    logic [ADC_BITS-1:0]   avg_i_out_reg;
    action_t               action_out_reg;

    logic [31:0]           win_full;
    logic [CNT_W-1:0]      win_len;
    logic [CNT_W-1:0]      taken;
    logic [SUM_W-1:0]      v_sum_next;
    logic [SUM_W-1:0]      i_sum_next;
    logic [CNT_W:0]        v_shift;
    logic [CNT_W:0]        i_shift;
    logic                  v_ge;
    logic                  i_ge;
    logic [CNT_W:0]        v_rem_next;
    logic [CNT_W:0]        i_rem_next;
    logic [ADC_BITS-1:0]   v_avg;
    logic [ADC_BITS-1:0]   i_avg;
    logic signed [S_W-1:0] s_sum;
    logic                  s_pos;
    logic                  s_neg;
    logic                  raise;
    logic                  lower;
    logic [DUTY_W-1:0]     duty_next;
    action_t               action_next;

    // window length: zero counts as one, large counts saturate
    always_comb
    begin
        if (sample_count == '0)
        begin
            win_full = 32'd1;
        end
        else if (32'(sample_count) > 32'(MAX_WINDOW))
        begin
            win_full = 32'(MAX_WINDOW);
        end
        else
        begin
            win_full = 32'(sample_count);
        end
    end

    assign win_len    = win_full[CNT_W-1:0];
    assign taken      = CNT_W'(sample_index_reg) + CNT_W'(1);
    assign v_sum_next = voltage_sum_reg + SUM_W'(voltage_sample);
    assign i_sum_next = current_sum_reg + SUM_W'(current_sample);

    // running sums and sample index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            voltage_sum_reg  <= '0;
            current_sum_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (status.close)
            begin
                sample_index_reg <= '0;
                voltage_sum_reg  <= '0;
                current_sum_reg  <= '0;
            end
            else
            begin
                sample_index_reg <= taken[IDX_W-1:0];
                voltage_sum_reg  <= v_sum_next;
                current_sum_reg  <= i_sum_next;
            end
        end
    end

    // one quotient bit per cycle for each channel
    assign v_shift    = {vrem_reg, vq_reg[SUM_W-1]};
    assign i_shift    = {irem_reg, iq_reg[SUM_W-1]};
    assign v_ge       = v_shift >= {1'b0, divisor_reg};
    assign i_ge       = i_shift >= {1'b0, divisor_reg};
    assign v_rem_next = v_ge ? (v_shift - {1'b0, divisor_reg}) : v_shift;
    assign i_rem_next = i_ge ? (i_shift - {1'b0, divisor_reg}) : i_shift;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.close)
        begin
            vq_reg      <= v_sum_next;
            iq_reg      <= i_sum_next;
            vrem_reg    <= '0;
            irem_reg    <= '0;
            divisor_reg <= taken;
        end
        else if (cmd.div_step)
        begin
            vq_reg   <= {vq_reg[SUM_W-2:0], v_ge};
            iq_reg   <= {iq_reg[SUM_W-2:0], i_ge};
            vrem_reg <= v_rem_next[CNT_W-1:0];
            irem_reg <= i_rem_next[CNT_W-1:0];
        end
    end

    // divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_count_reg <= '0;
        end
        else if (cmd.accept && status.close)
        begin
            div_count_reg <= DCNT_W'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            div_count_reg <= div_count_reg - DCNT_W'(1);
        end
    end

    assign v_avg = vq_reg[ADC_BITS-1:0];
    assign i_avg = iq_reg[ADC_BITS-1:0];

    // changes against the previous window, then the two cross products
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dv_reg <= $signed({1'b0, v_avg}) - $signed({1'b0, prev_avg_voltage_reg});
            di_reg <= $signed({1'b0, i_avg}) - $signed({1'b0, prev_avg_current_reg});
        end
        if (cmd.mul)
        begin
            p1_reg <= PROD_W'(di_reg) * PROD_W'($signed({1'b0, v_avg}));
            p2_reg <= PROD_W'($signed({1'b0, i_avg})) * PROD_W'(dv_reg);
        end
    end

    // s = dI*V + I*dV, its sign flipped by the sign of dV
    assign s_sum = {p1_reg[PROD_W-1], p1_reg} + {p2_reg[PROD_W-1], p2_reg};
    assign s_neg = s_sum[S_W-1];
    assign s_pos = !s_sum[S_W-1] && (s_sum != '0);

    always_comb
    begin
        raise = 1'b0;
        lower = 1'b0;
        if (dv_reg == '0)
        begin
            raise = !di_reg[DIF_W-1] && (di_reg != '0);
            lower = di_reg[DIF_W-1];
        end
        else if (v_avg == '0)
        begin
            raise = 1'b0;
            lower = 1'b0;
        end
        else if (dv_reg[DIF_W-1])
        begin
            raise = s_neg;
            lower = s_pos;
        end
        else
        begin
            raise = s_pos;
            lower = s_neg;
        end
    end

    // duty update within the limits
    always_comb
    begin
        duty_next   = duty_reg;
        action_next = ACT_HOLD;
        if (raise)
        begin
            if (duty_reg < duty_max)
            begin
                duty_next   = duty_reg + DUTY_W'(1);
                action_next = ACT_RAISED;
            end
            else
            begin
                action_next = ACT_AT_MAX;
            end
        end
        else if (lower)
        begin
            if (duty_reg > duty_min)
            begin
                duty_next   = duty_reg - DUTY_W'(1);
                action_next = ACT_LOWERED;
            end
            else
            begin
                action_next = ACT_AT_MIN;
            end
        end
    end

    // tracker state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg             <= '0;
            prev_avg_voltage_reg <= '0;
            prev_avg_current_reg <= '0;
            out_valid_reg        <= 1'b0;
        end
        else if (cmd.step)
        begin
            duty_reg             <= duty_next;
            prev_avg_voltage_reg <= v_avg;
            prev_avg_current_reg <= i_avg;
            out_valid_reg        <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            duty_out_reg   <= duty_next;
            avg_v_out_reg  <= v_avg;
            avg_i_out_reg  <= i_avg;
            action_out_reg <= action_next;
        end
    end

    assign status.close    = taken >= win_len;
    assign status.div_last = div_count_reg == DCNT_W'(1);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign duty_percent = duty_out_reg;
    assign avg_voltage  = avg_v_out_reg;
    assign avg_current  = avg_i_out_reg;
    assign action       = action_out_reg;

endmodule

// ----- rtl/core/mppt_incremental_conductance.sv -----
// ----------------------------------------------------------------------------
// mppt_incremental_conductance
// Averages paired voltage/current samples over a window and runs one
// incremental-conductance step per window, giving the new duty cycle.
// Throughput: one sample per cycle while a window is open; the sample that
//   closes a window holds the sample port through the bit-serial divide of
//   the averages and the difference, multiply and step phases.
// Result: the result transaction is loaded in the step state, after the divide,
//   difference and multiply states that follow the closing sample; the step
//   state waits while the previous result is still held.
// Reset: sums, index, previous averages and duty cleared; sample_count 1000,
//   duty_max 80, duty_min 20; no result pending.
// ----------------------------------------------------------------------------
module mppt_incremental_conductance #(
    parameter int ADC_BITS   = 12,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ADC_BITS-1:0]               voltage_sample,
    input  logic [ADC_BITS-1:0]               current_sample,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mppt_ic_pkg::DUTY_W-1:0]    duty_percent,
    output logic [ADC_BITS-1:0]               avg_voltage,
    output logic [ADC_BITS-1:0]               avg_current,
    output mppt_ic_pkg::action_t              action
);
    import mppt_ic_pkg::*;

    logic [SAMPLE_COUNT_W-1:0] sample_count_reg;
    logic [SAMPLE_COUNT_W-1:0] sample_count_next;
    logic [DUTY_W-1:0]         duty_max_reg;
    logic [DUTY_W-1:0]         duty_max_next;
    logic [DUTY_W-1:0]         duty_min_reg;
    logic [DUTY_W-1:0]         duty_min_next;
    logic                      cfg_write;
    dp_cmd_t                   cmd;
    dp_status_t                status;

    // configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        duty_max_next     = duty_max_reg;
        duty_min_next     = duty_min_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SAMPLE_COUNT: sample_count_next = pwdata[SAMPLE_COUNT_W-1:0];
                REG_DUTY_MAX:     duty_max_next     = pwdata[DUTY_W-1:0];
                REG_DUTY_MIN:     duty_min_next     = pwdata[DUTY_W-1:0];
                default:          sample_count_next = sample_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            duty_max_reg     <= DUTY_MAX_RST;
            duty_min_reg     <= DUTY_MIN_RST;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            duty_max_reg     <= duty_max_next;
            duty_min_reg     <= duty_min_next;
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_SAMPLE_COUNT: prdata = 32'(sample_count_reg);
            REG_DUTY_MAX:     prdata = 32'(duty_max_reg);
            REG_DUTY_MIN:     prdata = 32'(duty_min_reg);
            default:          prdata = '0;
        endcase
    end

    // sequencer
    mppt_ic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and output register
    mppt_ic_datapath #(
        .ADC_BITS   (ADC_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .voltage_sample (voltage_sample),
        .current_sample (current_sample),
        .sample_count   (sample_count_reg),
        .duty_max       (duty_max_reg),
        .duty_min       (duty_min_reg),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .duty_percent   (duty_percent),
        .avg_voltage    (avg_voltage),
        .avg_current    (avg_current),
        .action         (action)
    );

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.div_step, cmd.diff, cmd.mul, cmd.step}))
    else $error("more than one datapath command in a cycle");

    // a new result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transaction");

    // no sample is taken while a window step is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.diff || cmd.mul) |-> !in_ready)
    else $error("sample port open during a tracking step");

    // a raised duty is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == ACT_RAISED)) |-> (duty_percent != '0))
    else $error("raised duty reads zero");

endmodule
